FILE: src/lbs4_pkg.sv
// ----------------------------------------------------------------------------
// lbs4_pkg
// Shared types and constants of the four-influence linear blend skinning block.
// ----------------------------------------------------------------------------
package lbs4_pkg;

   localparam int BoneCount     = 64;
   localparam int MaxInfluences = 4;
   localparam int SlotWords     = 12;
   localparam int StoreWords    = (BoneCount + 1) * SlotWords;
   localparam int AddrWidth     = $clog2(StoreWords);
   localparam int SlotWidth     = 7;
   localparam int BoneWidth     = 6;
   localparam int FracWidth     = 12;
   localparam int InfWidth      = BoneWidth + FracWidth;
   localparam int InfIdxWidth   = 2;
   localparam int FracMin       = 5;
   localparam int WeightScale   = 10;

   // accumulator widths: T needs 49 bits, a four-bone blend 55 bits
   localparam int TermWidth   = 49;
   localparam int AccWidth    = 56;
   // T is weighted in two multiplies, high part then low part
   localparam int WeightSplit = 24;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_VERTEX = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_WEIGHT,
      ST_WEIGHT_LO,
      ST_NEXT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } seq_ctl_type;

   function automatic logic [31:0] sat32(input logic signed [AccWidth-1:0] v);
      logic [31:0] r;
      if (v > $signed({{(AccWidth-32){1'b0}}, 32'h7fffffff})) begin
         r = 32'h7fffffff;
      end else if (v < $signed({{(AccWidth-32){1'b1}}, 32'h80000000})) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: src/lbs4_ram.sv
// ----------------------------------------------------------------------------
// lbs4_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lbs4_ram #(
   parameter int Width = 32,
   parameter int Depth = 780
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

FILE: src/lbs4_mac.sv
// ----------------------------------------------------------------------------
// lbs4_mac
// Shared 36x32 multiplier with a product register.
// ----------------------------------------------------------------------------
module lbs4_mac (
   input  logic               clock,
   input  logic signed [35:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [67:0] prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end
endmodule

FILE: src/linear_blend_skinning_4bone_top.sv
// one request at a time; the pace is set by the RAM port and multiplier
// each coordinate takes four matrix reads, each through READ, MUL and ACC; a skinned one adds two weight multiplies
// a waiting response holds only the output step, not the next request
// reset: synchronous, clears control state and skinning_enable; matrix RAM is not cleared
// ----------------------------------------------------------------------------
// linear_blend_skinning_4bone_top
// Four-influence linear blend skinning with a shared multiplier sequencer.
// ----------------------------------------------------------------------------
module linear_blend_skinning_4bone_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_skinning_enable,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_mode,
   input  logic [6:0]   req_matrix_slot,
   input  logic [3:0]   req_matrix_element,
   input  logic [31:0]  req_matrix_word,
   input  logic [31:0]  req_vertex_x,
   input  logic [31:0]  req_vertex_y,
   input  logic [31:0]  req_vertex_z,
   input  logic [17:0]  req_influence_0,
   input  logic [17:0]  req_influence_1,
   input  logic [17:0]  req_influence_2,
   input  logic [17:0]  req_influence_3,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [31:0]  rsp_out_x,
   output logic [31:0]  rsp_out_y,
   output logic [31:0]  rsp_out_z
);
   import lbs4_pkg::*;

   state_type state_ff, state_in;
   logic skin_ff;
   logic signed [31:0] p_ff [3];
   logic [InfWidth-1:0] inf_ff [MaxInfluences];
   logic [InfIdxWidth-1:0] inf_idx_ff, inf_idx_in;
   logic [SlotWidth-1:0] slot_ff, slot_in;
   logic [1:0] col_ff, col_in;
   logic [1:0] row_ff, row_in;
   logic signed [TermWidth-1:0] t_ff, t_in;
   logic signed [AccWidth-1:0] acc_ff [3];
   logic signed [AccWidth-1:0] acc_in [3];
   logic rsp_valid_ff;
   logic [31:0] out_ff [3];
   logic wr_en;
   logic [AddrWidth-1:0] addr;
   logic [31:0] rd_data;
   logic signed [35:0] op_a;
   logic signed [67:0] prod;
   logic signed [67:0] wprod_ff;
   logic weighting;
   logic out_fire;
   logic [3:0] elem;
   logic signed [AccWidth-1:0] wsum;
   logic [FracWidth-1:0] frac;
   logic [BoneWidth-1:0] bone;
   logic [AddrWidth-1:0] slot_base;
   seq_ctl_type ctl;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         skin_ff <= 1'b0;
      end else if (csr_valid) begin
         skin_ff <= csr_skinning_enable;
      end
   end

   assign ctl.busy  = (state_ff != ST_IDLE);
   assign ctl.start = req_valid && req_ready && (req_mode == MODE_VERTEX);
   assign req_ready = !ctl.busy;
   assign out_fire  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign frac = inf_ff[inf_idx_ff][FracWidth-1:0];
   assign bone = inf_ff[inf_idx_ff][InfWidth-1:FracWidth];

   // element: rows 0..2 linear, row 3 translation
   assign elem = 4'(row_ff) * 4'd3 + 4'(col_ff);
   assign slot_base = AddrWidth'(slot_ff) * AddrWidth'(SlotWords);
   assign wr_en = req_valid && req_ready && (req_mode == MODE_LOAD)
                  && (req_matrix_element < 4'(SlotWords))
                  && (req_matrix_slot <= SlotWidth'(BoneCount));
   assign addr = wr_en ? AddrWidth'(req_matrix_slot) * AddrWidth'(SlotWords)
                         + AddrWidth'(req_matrix_element)
                       : slot_base + AddrWidth'(elem);

   lbs4_ram #(.Width(32), .Depth(StoreWords)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (addr),
      .wr_data(req_matrix_word),
      .rd_data(rd_data)
   );

   assign weighting = (state_ff == ST_WEIGHT) || (state_ff == ST_WEIGHT_LO);
   assign op_a = (state_ff == ST_WEIGHT) ? 36'($signed(t_ff[TermWidth-1:WeightSplit]))
               : (state_ff == ST_WEIGHT_LO) ? 36'(t_ff[WeightSplit-1:0])
               : 36'(p_ff[row_ff[1:0] == 2'd3 ? 2'd0 : row_ff]);
   lbs4_mac u_mac (
      .clock  (clock),
      .op_a   (op_a),
      .op_b   (weighting ? 32'(frac) * 32'(WeightScale) : rd_data),
      .prod_ff(prod)
   );

   assign wsum = AccWidth'((wprod_ff + prod + 68'sd2048) >>> 12);

   always_comb begin
      state_in   = state_ff;
      inf_idx_in = inf_idx_ff;
      slot_in    = slot_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      t_in       = t_ff;
      for (int i = 0; i < 3; i++) acc_in[i] = acc_ff[i];
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               for (int i = 0; i < 3; i++) acc_in[i] = '0;
               inf_idx_in = '0;
               col_in = '0;
               row_in = '0;
               t_in = '0;
               slot_in = SlotWidth'(BoneCount);
               if (skin_ff) begin
                  state_in = ST_NEXT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_NEXT: begin
            if (32'(frac) < 32'(FracMin)) begin
               state_in = ST_OUT;
            end else if (32'(bone) >= 32'(BoneCount)) begin
               if (32'(inf_idx_ff) == 32'(MaxInfluences - 1)) state_in = ST_OUT;
               inf_idx_in = inf_idx_ff + 1'b1;
            end else begin
               slot_in = SlotWidth'(bone);
               col_in = '0;
               row_in = '0;
               t_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL: begin
            if (row_ff == 2'd3) begin
               t_in = t_ff + TermWidth'($signed(rd_data));
               if (skin_ff) begin
                  state_in = ST_WEIGHT;
               end else begin
                  acc_in[col_ff] = AccWidth'(t_in);
                  state_in = ST_ACC;
               end
            end else begin
               state_in = ST_ACC;
            end
         end
         ST_WEIGHT: state_in = ST_WEIGHT_LO;
         ST_WEIGHT_LO: state_in = ST_ACC;
         ST_ACC: begin
            if (row_ff == 2'd3) begin
               if (skin_ff) acc_in[col_ff] = acc_ff[col_ff] + wsum;
               t_in = '0;
               row_in = '0;
               if (col_ff == 2'd2) begin
                  if (!skin_ff || 32'(inf_idx_ff) == 32'(MaxInfluences - 1)) begin
                     state_in = ST_OUT;
                  end else begin
                     inf_idx_in = inf_idx_ff + 1'b1;
                     state_in = ST_NEXT;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else begin
               t_in = t_ff + TermWidth'((prod + 68'sd32768) >>> 16);
               row_in = row_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_OUT: begin
            if (out_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      inf_idx_ff <= inf_idx_in;
      slot_ff    <= slot_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      t_ff       <= t_in;
      for (int i = 0; i < 3; i++) acc_ff[i] <= acc_in[i];
      if (state_ff == ST_WEIGHT_LO) begin
         wprod_ff <= prod <<< WeightSplit;
      end
      if (ctl.start) begin
         p_ff[0]   <= req_vertex_x;
         p_ff[1]   <= req_vertex_y;
         p_ff[2]   <= req_vertex_z;
         inf_ff[0] <= req_influence_0;
         inf_ff[1] <= req_influence_1;
         inf_ff[2] <= req_influence_2;
         inf_ff[3] <= req_influence_3;
      end
      if (out_fire) begin
         for (int i = 0; i < 3; i++) out_ff[i] <= sat32(acc_ff[i]);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.busy |-> !req_ready) else $error("request taken while busy");
   a_out_to_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> rsp_valid) else $error("result lost");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.busy |-> !wr_en) else $error("matrix write while busy");
`endif
endmodule
